// ===== src/cdq_pkg.sv =====
// Package for the circular deque: request and status codes, the shift
// command that steers the row of storage cells. No dependencies.
`default_nettype none

package cdq_pkg;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // result status carried on the output tuser
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OCC_W  = 4;

  // command broadcast to every cell; at most one bit is set
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_op_t;

endpackage : cdq_pkg

`default_nettype wire

// ===== src/circular_deque.sv =====
// Top level of the byte deque: request decode, item count, result register.
// Depends on cdq_pkg and cdq_chain.
//
//   channel | dir | tdata                         | tuser
//   --------+-----+-------------------------------+----------------
//   in_     | in  | [7:0] push_byte               | [1:0] req_type
//   out_    | out | [7:0] pop_byte, [11:8] occ.   | [1:0] status
//
// One request per cycle while the output is not stalled; each result appears in the cycle after its transfer.
// The output register lets a new request in whenever it is empty or taken.
// The longest path is the one-hot rear tap across all DEPTH-1 cells.
// Reset empties the row; no clearing pass is needed.
// A stalled output holds its result and blocks further input transfers.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] push_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] pop_byte, [11:8] occupancy, rest zero
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int unsigned CW = $clog2(DEPTH);

  logic              in_xfer;
  logic              empty, full;
  logic [BYTE_W-1:0] front_byte, rear_byte;
  cdq_op_t           op;
  logic [1:0]        status;
  logic [BYTE_W-1:0] pop_byte;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW+OCC_W-1:0] occ_ext;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] pop_byte_r;
  logic [1:0]        status_r;
  logic [OCC_W-1:0]  occ_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // decode the request; refuse overflow and underflow
  always_comb begin
    op       = '0;
    status   = ST_DONE;
    pop_byte = '0;
    case (in_tuser)
      REQ_PUSH_REAR: begin
        if (full) status = ST_OVERFLOW;
        else      op.push_rear = in_xfer;
      end
      REQ_PUSH_FRONT: begin
        if (full) status = ST_OVERFLOW;
        else      op.push_front = in_xfer;
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          op.pop_front = in_xfer;
          pop_byte     = front_byte;
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          op.pop_rear = in_xfer;
          pop_byte    = rear_byte;
        end
      end
      default: begin
        op = '0;
      end
    endcase
  end

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .push_byte  (in_tdata),
    .empty      (empty),
    .full       (full),
    .front_byte (front_byte),
    .rear_byte  (rear_byte)
  );

  // track the number of items held
  always_comb begin
    count_nxt = count_r;
    if (op.push_front || op.push_rear) begin
      count_nxt = count_r + CW'(1);
    end else if (op.pop_front || op.pop_rear) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  // hold the result until the output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pop_byte_r <= pop_byte;
      status_r   <= status;
      occ_r      <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, occ_r, pop_byte_r};
  assign out_tuser  = status_r;

endmodule : circular_deque

`default_nettype wire

// ===== src/cdq_cell.sv =====
// One storage cell of the deque row: a valid flag and a byte.
// Depends on cdq_pkg for the shift command type.
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdq_op_t           op,
  input  wire logic              left_valid,
  input  wire logic [BYTE_W-1:0] left_data,
  input  wire logic              right_valid,
  input  wire logic [BYTE_W-1:0] right_data,
  input  wire logic [BYTE_W-1:0] push_byte,
  output logic                   valid,
  output logic [BYTE_W-1:0]      data
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;

  // take from the left neighbour, the right neighbour or the pushed byte
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (op.push_front) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (op.pop_front) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (op.push_rear) begin
      // first empty cell behind the last item takes the byte
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = push_byte;
      end
    end else if (op.pop_rear) begin
      // the last item drops its flag
      valid_nxt = valid_r & right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule : cdq_cell

`default_nettype wire

// ===== src/cdq_chain.sv =====
// Row of DEPTH-1 deque cells with the front item in cell 0, and the tap
// that picks the rear item. Depends on cdq_pkg and cdq_cell.
`default_nettype none

module cdq_chain
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdq_op_t           op,
  input  wire logic [BYTE_W-1:0] push_byte,
  output logic                   empty,
  output logic                   full,
  output logic [BYTE_W-1:0]      front_byte,
  output logic [BYTE_W-1:0]      rear_byte
);

  localparam int unsigned NCELL = DEPTH - 1;

  logic              cell_valid [NCELL];
  logic [BYTE_W-1:0] cell_data  [NCELL];
  logic [BYTE_W-1:0] rear_tap   [NCELL];

  // build the row; cell 0 sees the pushed byte on its left
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic              lv, rv;
    logic [BYTE_W-1:0] ld, rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = push_byte;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .push_byte   (push_byte),
      .valid       (cell_valid[i]),
      .data        (cell_data[i])
    );

    // only the last valid cell drives its byte onto the rear tap
    assign rear_tap[i] = (cell_valid[i] && !rv) ? cell_data[i] : '0;
  end

  // combine the one-hot rear taps
  always_comb begin
    rear_byte = '0;
    for (int unsigned i = 0; i < NCELL; i++) begin
      rear_byte = rear_byte | rear_tap[i];
    end
  end

  assign empty      = !cell_valid[0];
  assign full       = cell_valid[NCELL-1];
  assign front_byte = cell_data[0];

endmodule : cdq_chain

`default_nettype wire

// ===== src/cdq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
// Depends on cdq_pkg for the status codes.
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH - 1);

  // an overflow is only reported with the deque full
  a_overflow_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_OVERFLOW) |-> out_tdata[11:8] == OCC_FULL)
    else $error("overflow reported while not full");

  // an underflow leaves an empty deque and no byte
  a_underflow_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_UNDERFLOW) |->
      (out_tdata[11:8] == '0 && out_tdata[7:0] == '0))
    else $error("underflow with items held or a byte returned");

  // every input transfer yields a result on the next cycle
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("result missing after input transfer");

  // a stalled result holds steady
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule : cdq_checker

bind circular_deque cdq_checker #(
  .DEPTH (DEPTH)
) u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/circular_deque_checker.sv =====
`timescale 1ns / 100ps
// Checker for the byte deque: watches both stream channels, keeps its own copy
// of the deque state, predicts every result and compares it. Needs cdq_pkg.

module circular_deque_checker
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] push_byte
  input  logic [1:0]        in_tuser,   // [1:0] req_type
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [15:0]       out_tdata,  // [7:0] pop_byte, [11:8] occupancy, rest zero
  input  logic [1:0]        out_tuser,  // [1:0] status
  output int unsigned       fail_count,
  output int unsigned       owed_count
);

  typedef struct packed {
    logic [BYTE_W-1:0] pop_byte;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } deque_result_t;

  // shadow copy of the store and both ends
  logic [BYTE_W-1:0] slot_copy [DEPTH];
  int unsigned       front_idx;
  int unsigned       rear_idx;
  deque_result_t     owed_results [$];

  initial begin
    fail_count = 0;
    owed_count = 0;
    front_idx  = DEPTH - 1;
    rear_idx   = DEPTH - 1;
  end

  function automatic int unsigned step_fwd(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  function automatic int unsigned step_back(int unsigned p);
    return (p + DEPTH - 1) % DEPTH;
  endfunction

  // Apply one request to the shadow deque and return the result it owes
  function automatic deque_result_t predict_request(logic [1:0] req, logic [7:0] data);
    deque_result_t res;
    bit            empty;
    bit            full;
    int unsigned   occ;
    res   = '0;
    res.status = ST_DONE;
    empty = (front_idx == rear_idx);
    full  = (step_fwd(rear_idx) == front_idx);
    case (req)
      REQ_PUSH_REAR: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          rear_idx            = step_fwd(rear_idx);
          slot_copy[rear_idx] = data;
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          slot_copy[front_idx] = data;
          front_idx            = step_back(front_idx);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          front_idx    = step_fwd(front_idx);
          res.pop_byte = slot_copy[front_idx];
        end
      end
      default: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.pop_byte = slot_copy[rear_idx];
          rear_idx     = step_back(rear_idx);
        end
      end
    endcase
    occ           = (rear_idx + DEPTH - front_idx) % DEPTH;
    res.occupancy = occ[OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare the result transfer first, then book the new request: a result
  // never leaves in the cycle of its own request
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (!rst_n) begin
      front_idx = DEPTH - 1;
      rear_idx  = DEPTH - 1;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing owed: tdata %0h, tuser %0h",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("pop_byte", want.pop_byte, out_tdata[7:0]);
          check_field("occupancy", 8'(want.occupancy), 8'(out_tdata[11:8]));
          check_field("tdata padding", 8'h00, 8'(out_tdata[15:12]));
          check_field("status", 8'(want.status), 8'(out_tuser));
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(predict_request(in_tuser, in_tdata));
    end
    owed_count = owed_results.size();
  end

endmodule : circular_deque_checker

// ===== tb/circular_deque_tb.sv =====
`timescale 1ns / 100ps
// Top of the byte deque testbench: clock, reset, request stimulus and output
// back-pressure. Needs cdq_pkg, circular_deque and circular_deque_checker.

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] push_byte
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] pop_byte, [11:8] occupancy, rest zero
  logic [1:0]  out_tuser;  // [1:0] status

  int unsigned fail_count;
  int unsigned owed_count;
  bit          quiet;      // when set, neither side idles

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  circular_deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, after an optional gap, and hold it until its transfer
  task automatic send_request(logic [1:0] req, logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
  endtask

  // Back-pressure on the result channel: one assignment per falling edge
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    logic [1:0]  req;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_PUSH_REAR;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Underflow on both ends of the empty deque
    send_request(REQ_POP_FRONT, 8'h00);
    send_request(REQ_POP_REAR, 8'hFF);
    // Extreme bytes in at each end, out at the same end
    send_request(REQ_PUSH_REAR, 8'h00);
    send_request(REQ_PUSH_FRONT, 8'hFF);
    send_request(REQ_POP_FRONT, 8'h00);
    send_request(REQ_POP_REAR, 8'hFF);
    // Fill to capacity from both ends, overflow at each end, then pop at each end
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_request(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_REAR,
                   i[1] ? 8'hAA ^ 8'(i) : 8'h55 ^ 8'(i << 4));
    end
    send_request(REQ_PUSH_REAR, 8'h5A);
    send_request(REQ_PUSH_FRONT, 8'hA5);
    send_request(REQ_POP_FRONT, 8'h00);
    send_request(REQ_POP_REAR, 8'h00);

    // Random phases leaning towards filling, draining or neither, so the
    // deque keeps hitting full and empty while the pointers wrap
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
        else
          req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
        send_request(req, 8'($urandom));
        sent++;
      end
    end

    // Drop valid, drain what is owed, then keep the clock running for strays
    @(negedge clk);
    in_tvalid = 1'b0;
    quiet     = 1'b0;
    while (owed_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule : circular_deque_tb
